### hdl/wav_stream_to_i2s_slots_assert.svh
// assertion macros shared by the wav stream blocks
// every use expects signals named clk and rst_n in the enclosing module
`ifndef WAV_STREAM_TO_I2S_SLOTS_ASSERT_SVH
`define WAV_STREAM_TO_I2S_SLOTS_ASSERT_SVH

// condition must hold at every clock edge out of reset
`define WSIS_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("wsis: invariant violated");

// consequent must hold in the same cycle as the antecedent
`define WSIS_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsis: implication violated");

// consequent must hold in the cycle after the antecedent
`define WSIS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsis: next-cycle implication violated");

`endif

### hdl/wsis_pkg.sv
package wsis_pkg;

    // one input item: a byte of the file
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } byte_item_t;

    // one result item
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] slot_sample;
        logic [31:0]        rate;
        logic [1:0]         channel_count;
        logic [2:0]         error_code;
        logic               end_mark;
    } result_t;

    localparam int RESULTS_MAX = 3;

    // up to three results produced by one byte, in order
    typedef struct packed {
        logic [1:0]                n;
        result_t [RESULTS_MAX-1:0] res;
    } push_t;

    // result kinds
    localparam logic [1:0] KIND_SLOT   = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_TAG      = 3'd1;
    localparam logic [2:0] ERR_BITS     = 3'd2;
    localparam logic [2:0] ERR_CHANNELS = 3'd3;
    localparam logic [2:0] ERR_DATA     = 3'd4;
    localparam logic [2:0] ERR_SHORT    = 3'd5;

    // configuration registers
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 19;
    localparam logic [0:0] REG_VOLUME_GAIN  = 1'b0;
    localparam logic [0:0] REG_DEFAULT_RATE = 1'b1;

    localparam logic [15:0] VOLUME_GAIN_RESET  = 16'd32768;
    localparam logic [18:0] DEFAULT_RATE_RESET = 19'd16000;

    // tags packed little-endian, byte 0 in bits 7:0
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam int QUEUE_DEPTH_DEFAULT = 8;

endpackage

### hdl/wsis_chan_if.sv
interface wsis_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

### hdl/wsis_parse.sv
`include "wav_stream_to_i2s_slots_assert.svh"

module wsis_parse
    import wsis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  byte_item_t            in_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output push_t                 push
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_CHDR   = 3'd1;
    localparam logic [2:0] PH_SKIP   = 3'd2;
    localparam logic [2:0] PH_LO     = 3'd3;
    localparam logic [2:0] PH_HI     = 3'd4;
    localparam logic [2:0] PH_WAIT   = 3'd5;

    // offsets past the format header are never compared, so the count stops there
    localparam logic [5:0] OFF_SAT     = 6'd36;
    localparam logic [5:0] OFF_CH_LO   = 6'd22;
    localparam logic [5:0] OFF_CH_HI   = 6'd23;
    localparam logic [5:0] OFF_BITS_LO = 6'd34;
    localparam logic [5:0] OFF_BITS_HI = 6'd35;
    localparam logic [5:0] OFF_WAVE_END = 6'd11;
    localparam logic [5:0] OFF_DATA_MIN = 6'd35;

    logic [5:0]  off_reg, off_next;
    logic [2:0]  phase_reg, phase_next;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [7:0]  bits_lo_reg, bits_lo_next;
    logic [31:0] tag_reg, tag_next;
    logic [31:0] rem_reg, rem_next;
    logic [7:0]  hold_reg, hold_next;
    logic        mono_reg, mono_next;
    logic [15:0] gain_reg;
    logic [18:0] drate_reg;

    logic signed [15:0] smp_raw;
    logic signed [31:0] prod;
    logic signed [15:0] smp_scaled;

    function automatic result_t mk(
        input logic [1:0]         kind,
        input logic signed [15:0] smp,
        input logic [31:0]        rate,
        input logic [1:0]         ch,
        input logic [2:0]         err,
        input logic               endm
    );
        result_t r;
        r.kind          = kind;
        r.slot_sample   = smp;
        r.rate          = rate;
        r.channel_count = ch;
        r.error_code    = err;
        r.end_mark      = endm;
        return r;
    endfunction

    // q15 scaling: floor(s * g / 32768), unity at and above 32768
    assign smp_raw    = {in_item.data_byte, hold_reg};
    assign prod       = 32'(smp_raw) * 32'(signed'({1'b0, gain_reg[14:0]}));
    assign smp_scaled = gain_reg[15] ? smp_raw : prod[30:15];

    always_comb
    begin
        logic [1:0]  n;
        logic [2:0]  ph;
        logic [7:0]  b;
        logic [15:0] hdr_bits;
        logic [31:0] ann_rate;

        off_next     = off_reg;
        phase_next   = phase_reg;
        chan_next    = chan_reg;
        rate_next    = rate_reg;
        bits_lo_next = bits_lo_reg;
        tag_next     = tag_reg;
        rem_next     = rem_reg;
        hold_next    = hold_reg;
        mono_next    = mono_reg;
        push         = '0;
        n            = 2'd0;
        ph           = phase_reg;
        b            = in_item.data_byte;
        hdr_bits     = {b, bits_lo_reg};
        ann_rate     = '0;

        if (in_fire)
        begin
            // header fields at fixed offsets
            if (ph != PH_WAIT)
            begin
                if (off_reg == OFF_CH_LO)
                    chan_next[7:0] = b;
                if (off_reg == OFF_CH_HI)
                    chan_next[15:8] = b;
                if (off_reg inside {[6'd24:6'd27]})
                    rate_next[8*off_reg[1:0] +: 8] = b;
                if (off_reg == OFF_BITS_LO)
                    bits_lo_next = b;
                if (off_reg == OFF_BITS_HI)
                begin
                    if (hdr_bits != 16'd16)
                    begin
                        push.res[n] = mk(KIND_ERROR, '0, '0, '0, ERR_BITS, 1'b1);
                        n = n + 2'd1;
                        ph = PH_WAIT;
                    end
                    else if (chan_reg != 16'd1 && chan_reg != 16'd2)
                    begin
                        push.res[n] = mk(KIND_ERROR, '0, '0, '0, ERR_CHANNELS, 1'b1);
                        n = n + 2'd1;
                        ph = PH_WAIT;
                    end
                end
            end

            case (ph)
                PH_HEADER:
                begin
                    if ((off_reg < 6'd4 && b != TAG_RIFF[8*off_reg[1:0] +: 8]) ||
                        ((off_reg inside {[6'd8:6'd11]}) &&
                         b != TAG_WAVE[8*off_reg[1:0] +: 8]))
                    begin
                        push.res[n] = mk(KIND_ERROR, '0, '0, '0, ERR_TAG, 1'b1);
                        n = n + 2'd1;
                        ph = PH_WAIT;
                    end
                    else if (off_reg == OFF_WAVE_END)
                    begin
                        ph = PH_CHDR;
                        hold_next = '0;
                    end
                end
                PH_CHDR:
                begin
                    // tag bytes then size bytes, shifted in from the top
                    if (hold_reg < 8'd4)
                        tag_next = {b, tag_reg[31:8]};
                    else
                        rem_next = {b, rem_reg[31:8]};
                    if (hold_reg >= 8'd7)
                    begin
                        hold_next = '0;
                        if (tag_next == TAG_DATA)
                        begin
                            if (off_reg < OFF_DATA_MIN || rem_next == '0)
                            begin
                                push.res[n] = mk(KIND_ERROR, '0, '0, '0, ERR_DATA, 1'b1);
                                n = n + 2'd1;
                                ph = PH_WAIT;
                            end
                            else
                            begin
                                ann_rate = (rate_next != '0) ? rate_next
                                                             : 32'(drate_reg);
                                mono_next = (chan_next != 16'd2);
                                push.res[n] = mk(KIND_FORMAT, '0, ann_rate,
                                                 (chan_next == 16'd2) ? 2'd2 : 2'd1,
                                                 ERR_NONE, 1'b0);
                                n = n + 2'd1;
                                ph = PH_LO;
                            end
                        end
                        else
                        begin
                            ph = (rem_next != '0) ? PH_SKIP : PH_CHDR;
                        end
                    end
                    else
                    begin
                        hold_next = hold_reg + 8'd1;
                    end
                end
                PH_SKIP:
                begin
                    rem_next = rem_reg - 32'd1;
                    if (rem_next == '0)
                    begin
                        ph = PH_CHDR;
                        hold_next = '0;
                    end
                end
                PH_LO:
                begin
                    hold_next = b;
                    rem_next = rem_reg - 32'd1;
                    ph = PH_HI;
                end
                PH_HI:
                begin
                    push.res[n] = mk(KIND_SLOT, smp_scaled, '0, '0, ERR_NONE, 1'b0);
                    n = n + 2'd1;
                    if (mono_reg)
                    begin
                        push.res[n] = mk(KIND_SLOT, smp_scaled, '0, '0, ERR_NONE, 1'b0);
                        n = n + 2'd1;
                    end
                    rem_next = rem_reg - 32'd1;
                    ph = PH_LO;
                end
                default:
                begin
                end
            endcase

            // payload exhausted
            if ((ph == PH_LO || ph == PH_HI) && rem_next == '0)
            begin
                push.res[n] = mk(KIND_DONE, '0, '0, '0, ERR_NONE, 1'b1);
                n = n + 2'd1;
                ph = PH_WAIT;
                mono_next = 1'b1;
            end

            off_next = (off_reg == OFF_SAT) ? off_reg : off_reg + 6'd1;

            if (in_item.last)
            begin
                if (ph != PH_WAIT)
                begin
                    push.res[n] = mk(KIND_ERROR, '0, '0, '0, ERR_SHORT, 1'b1);
                    n = n + 2'd1;
                end
                ph           = PH_HEADER;
                off_next     = '0;
                chan_next    = '0;
                rate_next    = '0;
                bits_lo_next = '0;
                tag_next     = '0;
                rem_next     = '0;
                hold_next    = '0;
                mono_next    = 1'b1;
            end

            phase_next = ph;
        end
        push.n = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg     <= '0;
            phase_reg   <= PH_HEADER;
            chan_reg    <= '0;
            rate_reg    <= '0;
            bits_lo_reg <= '0;
            tag_reg     <= '0;
            rem_reg     <= '0;
            hold_reg    <= '0;
            mono_reg    <= 1'b1;
        end
        else
        begin
            off_reg     <= off_next;
            phase_reg   <= phase_next;
            chan_reg    <= chan_next;
            rate_reg    <= rate_next;
            bits_lo_reg <= bits_lo_next;
            tag_reg     <= tag_next;
            rem_reg     <= rem_next;
            hold_reg    <= hold_next;
            mono_reg    <= mono_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= VOLUME_GAIN_RESET;
            drate_reg <= DEFAULT_RATE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VOLUME_GAIN:  gain_reg  <= cfg_data[15:0];
                REG_DEFAULT_RATE: drate_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // a last byte always rearms the parser for the next file
    `WSIS_ASSERT_NEXT(a_last_rearms, in_fire && in_item.last,
                      phase_reg == PH_HEADER && off_reg == '0 && mono_reg)

endmodule

### hdl/wsis_resq.sv
`include "wav_stream_to_i2s_slots_assert.svh"

module wsis_resq
    import wsis_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t          q_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    function automatic logic [PTR_W-1:0] wrap_add(
        input logic [PTR_W-1:0] p,
        input logic [1:0]       k
    );
        logic [PTR_W:0] s;
        s = {1'b0, p} + (PTR_W+1)'(k);
        if (s >= (PTR_W+1)'(DEPTH))
            s = s - (PTR_W+1)'(DEPTH);
        return s[PTR_W-1:0];
    endfunction

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rd_ptr_reg];
    // room for the worst-case burst of one byte
    assign room      = (cnt_reg <= CNT_W'(DEPTH - RESULTS_MAX));

    assign wr_ptr_next = wrap_add(wr_ptr_reg, push.n);
    assign rd_ptr_next = pop ? wrap_add(rd_ptr_reg, 2'd1) : rd_ptr_reg;
    assign cnt_next    = cnt_reg + CNT_W'(push.n) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < RESULTS_MAX; i++)
        begin
            if (2'(i) < push.n)
                q_reg[wrap_add(wr_ptr_reg, 2'(i))] <= push.res[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    `WSIS_ASSERT_ALWAYS(a_cnt_bound, cnt_reg <= CNT_W'(DEPTH))
    `WSIS_ASSERT_IMPLY(a_push_fits, push.n != 2'd0,
                       32'(cnt_reg) + 32'(push.n) <= DEPTH + 32'(pop))
    `WSIS_ASSERT_NEXT(a_cnt_tracks, 1'b1,
                      cnt_reg == $past(cnt_reg) + CNT_W'($past(push.n)) - CNT_W'($past(pop)))

endmodule

### hdl/wav_stream_to_i2s_slots.sv
// wav file parser feeding i2s slot words
// bytes: sink channel, one byte of a riff/wave file per transfer, last marks
//   the final byte of the file; results: source channel, one result per
//   transfer (slot sample, format announce, done or error)
// cfg_we/cfg_index/cfg_data: write-only registers, volume gain and default
//   rate, written while no file is in flight
// order: the results of a byte are registered into the result queue at the byte
//   transfer and offered on results behind any already waiting, then drain at one per cycle while results.ready is high
// throughput: one byte per cycle while the result queue has room; the parse state
//   and the q15 gain multiply sit between the state registers and the result
//   queue, so a byte is fully handled in the cycle it is taken
// a byte can make up to three results; bytes is ready only while the
//   result queue has room for three more, so a stalled receiver backs up
//   into bytes once more than QUEUE_DEPTH - 3 results are waiting
// reset: parser back to the header phase, queue empty, volume gain at unity,
//   default rate 16000; after every last byte the parser rearms itself but
//   keeps the registers
module wav_stream_to_i2s_slots
    import wsis_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    wsis_chan_if.sink             bytes,
    wsis_chan_if.source           results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic       in_fire;
    logic       room;
    byte_item_t in_item;
    push_t      push;
    result_t    out_data;

    // bytes is ready whenever the queue can absorb a full burst
    assign bytes.ready = room;
    assign in_fire     = bytes.valid && bytes.ready;
    assign in_item     = bytes.payload;

    // header walk, chunk walk, sample assembly and gain in one pass
    wsis_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    // result queue decouples the byte side from the slot side
    wsis_resq #(
        .DEPTH (QUEUE_DEPTH)
    ) u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .out_data  (out_data)
    );

    assign results.payload = out_data;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import wsis_pkg::*;

    // chunk ids not in the package, packed little-endian like the others
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_LIST = 32'h5453_494C;

    // parser phases of the predictor
    typedef enum logic [2:0] {
        P_HEADER,
        P_CHUNK_HDR,
        P_SKIP,
        P_LOW,
        P_HIGH,
        P_IGNORE
    } parse_phase_e;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wsis_chan_if #(.payload_t(byte_item_t)) byte_ch ();
    wsis_chan_if #(.payload_t(result_t))    res_ch ();

    wav_stream_to_i2s_slots DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .bytes     (byte_ch),
        .results   (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and the parse state
    logic [15:0]  gain_reg;
    logic [18:0]  dflt_rate_reg;
    logic [31:0]  pos;
    parse_phase_e phase;
    logic [15:0]  fmt_channels;
    logic [31:0]  fmt_rate;
    logic [15:0]  fmt_bits;
    logic [31:0]  chunk_id;
    logic [31:0]  chunk_left;
    logic [7:0]   hold_byte;      // chunk header byte count, then held low sample byte
    logic [1:0]   slot_channels;

    // results predicted but not yet seen on the output
    result_t due_results[$];

    // bytes of the file being built
    logic [7:0] file_buf[$];

    // run control and bookkeeping
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int mismatch_count;
    int bytes_taken;
    int files_sent;
    int input_stalls;
    int kind_seen[4];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void rearm_parser();
        pos           = '0;
        phase         = P_HEADER;
        fmt_channels  = '0;
        fmt_rate      = '0;
        fmt_bits      = '0;
        chunk_id      = '0;
        chunk_left    = '0;
        hold_byte     = '0;
        slot_channels = 2'd1;
    endfunction

    function automatic void queue_result(logic [1:0] kind, logic signed [15:0] smp,
                                         logic [31:0] rate, logic [1:0] ch,
                                         logic [2:0] err, logic endm);
        result_t r;
        r.kind          = kind;
        r.slot_sample   = smp;
        r.rate          = rate;
        r.channel_count = ch;
        r.error_code    = err;
        r.end_mark      = endm;
        due_results.push_back(r);
    endfunction

    function automatic void queue_error(logic [2:0] err);
        queue_result(KIND_ERROR, '0, '0, '0, err, 1'b1);
    endfunction

    // q15 gain, anything above unity acts as unity, result floored
    function automatic logic signed [15:0] apply_gain(logic signed [15:0] s);
        logic [15:0] g;
        int          prod;
        g = (gain_reg > 16'd32768) ? 16'd32768 : gain_reg;
        if (g == 16'd32768)
            return s;
        prod = int'(s) * int'(g);
        return 16'(prod >>> 15);
    endfunction

    // works out the results of one accepted byte of the file
    function automatic void parse_wav_byte(logic [7:0] b, logic last_flag);
        logic [31:0]        off;
        logic signed [15:0] smp;
        logic [31:0]        ann_rate;
        off = pos;

        // fixed-offset header fields, captured whatever chunk they fall in
        if (phase != P_IGNORE)
        begin
            if (off == 22)
                fmt_channels[7:0] = b;
            if (off == 23)
                fmt_channels[15:8] = b;
            if (off >= 24 && off <= 27)
                fmt_rate[8*off[1:0] +: 8] = b;
            if (off == 34)
                fmt_bits[7:0] = b;
            if (off == 35)
            begin
                fmt_bits[15:8] = b;
                if (fmt_bits != 16'd16)
                begin
                    queue_error(ERR_BITS);
                    phase = P_IGNORE;
                end
                else if (fmt_channels != 16'd1 && fmt_channels != 16'd2)
                begin
                    queue_error(ERR_CHANNELS);
                    phase = P_IGNORE;
                end
            end
        end

        case (phase)
            P_HEADER:
            begin
                if ((off < 4 && b != TAG_RIFF[8*off[1:0] +: 8]) ||
                    (off >= 8 && off < 12 && b != TAG_WAVE[8*off[1:0] +: 8]))
                begin
                    queue_error(ERR_TAG);
                    phase = P_IGNORE;
                end
                else if (off == 11)
                begin
                    phase     = P_CHUNK_HDR;
                    hold_byte = '0;
                end
            end
            P_CHUNK_HDR:
            begin
                if (hold_byte < 4)
                    chunk_id = {b, chunk_id[31:8]};
                else
                    chunk_left = {b, chunk_left[31:8]};
                hold_byte++;
                if (hold_byte >= 8)
                begin
                    hold_byte = '0;
                    if (chunk_id == TAG_DATA)
                    begin
                        // payload must start at offset 36 or later and be non-empty
                        if (off < 35 || chunk_left == 0)
                        begin
                            queue_error(ERR_DATA);
                            phase = P_IGNORE;
                        end
                        else
                        begin
                            ann_rate      = (fmt_rate != 0) ? fmt_rate : {13'd0, dflt_rate_reg};
                            slot_channels = (fmt_channels == 16'd2) ? 2'd2 : 2'd1;
                            queue_result(KIND_FORMAT, '0, ann_rate, slot_channels,
                                         ERR_NONE, 1'b0);
                            phase = P_LOW;
                        end
                    end
                    else
                        phase = (chunk_left != 0) ? P_SKIP : P_CHUNK_HDR;
                end
            end
            P_SKIP:
            begin
                chunk_left--;
                if (chunk_left == 0)
                begin
                    phase     = P_CHUNK_HDR;
                    hold_byte = '0;
                end
            end
            P_LOW:
            begin
                hold_byte = b;
                chunk_left--;
                phase = P_HIGH;
            end
            P_HIGH:
            begin
                smp = apply_gain({b, hold_byte});
                queue_result(KIND_SLOT, smp, '0, '0, ERR_NONE, 1'b0);
                // mono goes out on both slots
                if (slot_channels == 2'd1)
                    queue_result(KIND_SLOT, smp, '0, '0, ERR_NONE, 1'b0);
                chunk_left--;
                phase = P_LOW;
            end
            default:
            begin
            end
        endcase

        if ((phase == P_LOW || phase == P_HIGH) && chunk_left == 0)
        begin
            queue_result(KIND_DONE, '0, '0, '0, ERR_NONE, 1'b1);
            phase         = P_IGNORE;
            slot_channels = 2'd1;
        end

        if (pos != '1)
            pos++;

        // file ends here, short unless already finished
        if (last_flag)
        begin
            if (phase != P_IGNORE)
                queue_error(ERR_SHORT);
            rearm_parser();
        end
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic note_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("[%0t] mismatch on%s", $realtime, what);
            $display("    expected kind=%0d smp=%0d rate=%0d ch=%0d err=%0d end=%0b",
                     want.kind, want.slot_sample, want.rate, want.channel_count,
                     want.error_code, want.end_mark);
            $display("    actual   kind=%0d smp=%0d rate=%0d ch=%0d err=%0d end=%0b",
                     got.kind, got.slot_sample, got.rate, got.channel_count,
                     got.error_code, got.end_mark);
        end
    endtask

    // byte transfers feed the predictor, result transfers are checked in order
    always @(posedge clk)
    begin : monitor
        result_t want;
        result_t got;
        string   diff;
        if (rst_n)
        begin
            if (byte_ch.valid && byte_ch.ready)
            begin
                parse_wav_byte(byte_ch.payload.data_byte, byte_ch.payload.last);
                bytes_taken++;
            end
            if (byte_ch.valid && !byte_ch.ready)
                input_stalls++;

            if (res_ch.valid && res_ch.ready)
            begin
                got = res_ch.payload;
                kind_seen[got.kind]++;
                if (due_results.size() == 0)
                    note_mismatch(" unexpected result", '0, got);
                else
                begin
                    want = due_results.pop_front();
                    diff = "";
                    if (got.kind !== want.kind)
                        diff = {diff, " kind"};
                    if (got.slot_sample !== want.slot_sample)
                        diff = {diff, " slot_sample"};
                    if (got.rate !== want.rate)
                        diff = {diff, " rate"};
                    if (got.channel_count !== want.channel_count)
                        diff = {diff, " channel_count"};
                    if (got.error_code !== want.error_code)
                        diff = {diff, " error_code"};
                    if (got.end_mark !== want.end_mark)
                        diff = {diff, " end_mark"};
                    if (diff != "")
                        note_mismatch(diff, want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    // receiver: random stalls, or a counted hold-off when one is armed
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                res_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // one byte transfer, with random idle cycles in front of it
    task automatic send_byte(logic [7:0] b, logic last_flag);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.payload <= '{data_byte: b, last: last_flag};
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    // stop offering, let every predicted result come out, then a few quiet cycles
    task automatic drain_block();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only called with the block drained
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_VOLUME_GAIN)
            gain_reg = value[15:0];
        else
            dflt_rate_reg = value;
    endtask

    // ------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------

    task automatic put_le(logic [31:0] value, int nbytes);
        int i;
        for (i = 0; i < nbytes; i++)
            file_buf.push_back(value[8*i +: 8]);
    endtask

    // riff/wave header plus a 16-byte fmt chunk, ends at offset 35
    task automatic begin_header(logic [15:0] ch, logic [31:0] rate, logic [15:0] bits);
        file_buf.delete();
        put_le(TAG_RIFF, 4);
        put_le($urandom, 4);
        put_le(TAG_WAVE, 4);
        put_le(TAG_FMT, 4);
        put_le(32'd16, 4);
        put_le(32'd1, 2);
        put_le(ch, 2);
        put_le(rate, 4);
        put_le($urandom, 4);
        put_le($urandom, 2);
        put_le(bits, 2);
    endtask

    // chunk header with its size, then body random bytes
    task automatic add_chunk(logic [31:0] id, logic [31:0] size, int body);
        put_le(id, 4);
        put_le(size, 4);
        repeat (body) file_buf.push_back(8'($urandom));
    endtask

    // whole buffer as one file, last on its final byte
    task automatic send_file();
        int i;
        for (i = 0; i < file_buf.size(); i++)
            send_byte(file_buf[i], i == file_buf.size() - 1);
        files_sent++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // riff and wave tag mismatches, later bytes ignored up to last
    task automatic test_tag_checks();
        file_buf.delete();
        put_le(32'h5846_4952, 4);     // "RIFX"
        file_buf.push_back(8'h00);
        send_file();

        file_buf.delete();
        file_buf.push_back(8'h00);
        send_file();

        // bad first byte of the wave tag
        begin_header(16'd1, 32'd8000, 16'd16);
        file_buf[8] = 8'h77;
        file_buf = file_buf[0:8];
        send_file();
        drain_block();
    endtask

    // bit depth checked at offset 35, ahead of a bad channel count
    task automatic test_format_checks();
        begin_header(16'd3, 32'd44100, 16'd24);
        send_file();
        drain_block();
    endtask

    // data chunk whose payload would start too early
    task automatic test_data_chunk_checks();
        file_buf.delete();
        put_le(TAG_RIFF, 4);
        put_le(32'd36, 4);
        put_le(TAG_WAVE, 4);
        add_chunk(TAG_DATA, 32'd4, 0);
        send_file();
        drain_block();
    endtask

    // last before done or error adds a short-file error
    task automatic test_early_end();
        file_buf.delete();
        file_buf.push_back(8'h52);
        send_file();

        // cut inside the first chunk header
        begin_header(16'd2, 32'd48000, 16'd16);
        file_buf = file_buf[0:12];
        send_file();
        drain_block();
    endtask

    // zero header rate takes the register, a chunk is skipped, odd size
    task automatic test_default_rate();
        write_reg(REG_DEFAULT_RATE, 19'd384000);
        begin_header(16'd1, 32'd0, 16'd16);
        add_chunk(TAG_LIST, 32'd1, 1);
        add_chunk(TAG_DATA, 32'd1, 1);
        send_file();
        drain_block();
        write_reg(REG_DEFAULT_RATE, DEFAULT_RATE_RESET);
    endtask

    // half gain, floor on negative samples, mono duplication
    task automatic test_gain_settings();
        write_reg(REG_VOLUME_GAIN, 19'd16384);
        begin_header(16'd1, 32'd8000, 16'd16);
        add_chunk(TAG_DATA, 32'd4, 0);
        put_le(32'h8000, 2);
        put_le(32'hFFFF, 2);
        send_file();
        drain_block();
    endtask

    // gain above unity on sample extremes while the receiver holds off long
    // enough for the result queue to fill and stall bytes
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_VOLUME_GAIN, 19'd65535);
        hold_left     = 150;
        begin_header(16'd1, 32'd22050, 16'd16);
        add_chunk(TAG_DATA, 32'd10, 0);
        put_le(32'h8000, 2);
        put_le(32'h7FFF, 2);
        put_le(32'h0000, 2);
        put_le(32'hFFFF, 2);
        put_le($urandom, 2);
        send_file();
        drain_block();
    endtask

    // time limit, far above the slowest correct run
    initial
    begin
        #20ms;
        $display("wav_stream_to_i2s_slots test failed");
        $finish;
    end

    initial
    begin : main
        int wait_cycles;
        rst_n           <= 1'b0;
        byte_ch.valid   <= 1'b0;
        byte_ch.payload <= '0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        gain_reg        = VOLUME_GAIN_RESET;
        dflt_rate_reg   = DEFAULT_RATE_RESET;
        rearm_parser();
        send_idle_pct   = 29;
        recv_idle_pct   = 87;
        hold_left       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tag_checks();
        test_format_checks();
        test_data_chunk_checks();
        test_early_end();

        send_idle_pct = 87;
        recv_idle_pct = 29;
        test_default_rate();
        test_gain_settings();

        test_backpressure();

        // bounded wait for stragglers, then a short quiet tail
        byte_ch.valid <= 1'b0;
        for (wait_cycles = 0; wait_cycles < 50000 && due_results.size() != 0; wait_cycles++)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (due_results.size() != 0)
        begin
            $display("%0d predicted results never came out", due_results.size());
            mismatch_count += due_results.size();
        end

        $display("ran %0d files, %0d bytes: %0d slot words, %0d formats, %0d done, %0d errors",
                 files_sent, bytes_taken, kind_seen[KIND_SLOT], kind_seen[KIND_FORMAT],
                 kind_seen[KIND_DONE], kind_seen[KIND_ERROR]);
        $display("bytes held off for %0d cycles by a full result queue, %0d mismatches",
                 input_stalls, mismatch_count);
        if (mismatch_count == 0)
            $display("wav_stream_to_i2s_slots test passed");
        else
            $display("wav_stream_to_i2s_slots test failed");
        $finish;
    end

endmodule

### wav_stream_to_i2s_slots.f
+incdir+hdl
hdl/wsis_pkg.sv
hdl/wsis_chan_if.sv
hdl/wsis_parse.sv
hdl/wsis_resq.sv
hdl/wav_stream_to_i2s_slots.sv
verif/tb_top.sv
